[design/ctk_pkg.sv]
// Shared types, codes and lookup tables for the C source tokenizer.
package ctk_pkg;

    localparam int KW_CHARS = 8;
    localparam int KW_COUNT = 32;
    localparam int OP_COUNT = 42;
    localparam int QUEUE_DEPTH = 4;
    localparam logic [15:0] LEN_CAP = 16'hFFFF;

    typedef enum logic [2:0] {
        M_IDLE, M_WORD, M_CONST, M_LIT, M_LINE, M_BLOCK, M_OPER
    } mode_t;

    localparam logic [3:0] CLS_KEYWORD = 4'd0;
    localparam logic [3:0] CLS_IDENT   = 4'd1;
    localparam logic [3:0] CLS_CONST   = 4'd2;
    localparam logic [3:0] CLS_LIT     = 4'd3;
    localparam logic [3:0] CLS_LINE    = 4'd4;
    localparam logic [3:0] CLS_BLOCK   = 4'd5;
    localparam logic [3:0] CLS_OPER    = 4'd6;
    localparam logic [3:0] CLS_BRACE   = 4'd7;
    localparam logic [3:0] CLS_PUNCT   = 4'd8;
    localparam logic [3:0] CLS_UNKNOWN = 4'd9;
    localparam logic [3:0] CLS_UNTERM  = 4'd10;

    typedef struct packed {
        logic [3:0]  cls;
        logic [5:0]  idx;
        logic [15:0] len;
        logic        last;
    } rec_t;

    typedef struct packed {
        logic [1:0]     cnt;
        rec_t [2:0]     rec;
    } push_t;

    typedef struct packed {
        mode_t        mode;
        logic [63:0]  wch;
        logic [15:0]  cnt;
        logic [15:0]  pend;
        logic [1:0]   pcnt;
        logic [7:0]   quote;
        logic         esc;
        logic         star;
    } st_t;

    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        {"auto", 32'h0}, {"break", 24'h0}, {"case", 32'h0}, {"char", 32'h0},
        {"const", 24'h0}, {"continue"}, {"default", 8'h0}, {"do", 48'h0},
        {"double", 16'h0}, {"else", 32'h0}, {"enum", 32'h0}, {"extern", 16'h0},
        {"float", 24'h0}, {"for", 40'h0}, {"goto", 32'h0}, {"if", 48'h0},
        {"int", 40'h0}, {"long", 32'h0}, {"register"}, {"return", 16'h0},
        {"short", 24'h0}, {"signed", 16'h0}, {"sizeof", 16'h0}, {"static", 16'h0},
        {"struct", 16'h0}, {"switch", 16'h0}, {"typedef", 8'h0}, {"union", 24'h0},
        {"unsigned"}, {"void", 32'h0}, {"volatile"}, {"while", 24'h0}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
        4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
        4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
    };

    localparam logic [23:0] OP_TEXT [OP_COUNT] = '{
        {"<<="}, {">>="}, {"+=", 8'h0}, {"-=", 8'h0}, {"*=", 8'h0},
        {"/=", 8'h0}, {"%=", 8'h0}, {"&=", 8'h0}, {"|=", 8'h0}, {"^=", 8'h0},
        {"++", 8'h0}, {"--", 8'h0}, {"->", 8'h0}, {"<<", 8'h0}, {">>", 8'h0},
        {"<=", 8'h0}, {">=", 8'h0}, {"==", 8'h0}, {"!=", 8'h0}, {"&&", 8'h0},
        {"||", 8'h0},
        {"=", 16'h0}, {"+", 16'h0}, {"-", 16'h0}, {"*", 16'h0}, {"/", 16'h0},
        {"%", 16'h0}, {"<", 16'h0}, {">", 16'h0}, {"!", 16'h0}, {"&", 16'h0},
        {"|", 16'h0}, {"~", 16'h0}, {"^", 16'h0}, {"?", 16'h0}, {":", 16'h0},
        {".", 16'h0}, {"#", 16'h0}, {"[", 16'h0}, {"]", 16'h0}, {"(", 16'h0},
        {")", 16'h0}
    };

    localparam logic [1:0] OP_LEN [OP_COUNT] = '{
        2'd3, 2'd3, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1
    };

endpackage

[design/ctk_step.sv]
// Scanner state and per-byte token logic producing up to two records.
module ctk_step (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          fire,
    input  logic [7:0]    char_in,
    input  logic          eot,
    output ctk_pkg::push_t push
);
    import ctk_pkg::*;

    st_t st_reg, st_next;

    function automatic st_t to_idle(st_t s);
        s.mode = M_IDLE;
        s.cnt  = '0;
        s.pend = '0;
        s.pcnt = '0;
        s.esc  = 1'b0;
        s.star = 1'b0;
        return s;
    endfunction

    function automatic st_t bump(st_t s);
        if (s.cnt != LEN_CAP) begin
            s.cnt = s.cnt + 16'd1;
        end
        return s;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [23:0] op_mask(logic [1:0] n);
        logic [23:0] m;
        case (n)
            2'd1: m = 24'hFF0000;
            2'd2: m = 24'hFFFF00;
            default: m = 24'hFFFFFF;
        endcase
        return m;
    endfunction

    function automatic logic op_prefix(logic [23:0] s, logic [1:0] n);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < OP_COUNT; i++) begin
            if (OP_LEN[i] >= n && ((s ^ OP_TEXT[i]) & op_mask(n)) == 24'h0) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic rec_t op_record(logic [23:0] s, logic [1:0] n);
        rec_t r;
        r = '{cls: CLS_UNKNOWN, idx: 6'd0, len: {14'd0, n}, last: 1'b0};
        for (int i = OP_COUNT - 1; i >= 0; i--) begin
            if (OP_LEN[i] == n && ((s ^ OP_TEXT[i]) & op_mask(n)) == 24'h0) begin
                r.cls = CLS_OPER;
                r.idx = 6'(i);
            end
        end
        return r;
    endfunction

    function automatic rec_t flush_word(st_t s);
        rec_t r;
        logic [63:0] m;
        r = '{cls: CLS_IDENT, idx: 6'd0, len: s.cnt, last: 1'b0};
        if (s.cnt <= 16'(KW_CHARS)) begin
            for (int i = KW_COUNT - 1; i >= 0; i--) begin
                m = ~(64'hFFFF_FFFF_FFFF_FFFF >> {KW_LEN[i], 3'b000});
                if ({12'd0, KW_LEN[i]} == s.cnt && ((s.wch ^ KW_TEXT[i]) & m) == 64'h0) begin
                    r.cls = CLS_KEYWORD;
                    r.idx = 6'(i);
                end
            end
        end
        return r;
    endfunction

    function automatic st_t start_token(st_t s, logic [7:0] c, output rec_t r,
                                        output logic e);
        s = to_idle(s);
        e = 1'b0;
        r = '{cls: CLS_UNKNOWN, idx: 6'd0, len: 16'd1, last: 1'b0};
        if (c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D) begin
            e = 1'b0;
        end else if (is_alpha(c)) begin
            s.mode = M_WORD;
            s.cnt  = 16'd1;
            s.wch[63:56] = c;
        end else if (is_digit(c)) begin
            s.mode = M_CONST;
            s.cnt  = 16'd1;
        end else if (c == 8'h27 || c == 8'h22) begin
            s.mode  = M_LIT;
            s.quote = c;
            s.cnt   = 16'd1;
        end else if (op_prefix({c, 16'h0}, 2'd1)) begin
            s.mode = M_OPER;
            s.pend = {8'h0, c};
            s.pcnt = 2'd1;
        end else if (c == "{" || c == "}") begin
            e = 1'b1;
            r.cls = CLS_BRACE;
        end else if (c == ";" || c == ",") begin
            e = 1'b1;
            r.cls = CLS_PUNCT;
        end else begin
            e = 1'b1;
        end
        return s;
    endfunction

    always_comb begin
        st_t s;
        rec_t r;
        logic e;
        logic [1:0] n;
        logic [1:0] k;
        rec_t [2:0] recs;
        logic [7:0] c;
        logic [7:0] s0;
        logic [7:0] s1;

        s = st_reg;
        c = char_in;
        k = 2'd0;
        recs = '0;
        e = 1'b0;
        r = '0;
        n = (st_reg.pcnt == 2'd3) ? 2'd2 : st_reg.pcnt;
        s0 = st_reg.pend[7:0];
        s1 = st_reg.pend[15:8];

        case (st_reg.mode)
            M_WORD: begin
                if (is_alpha(c) || is_digit(c)) begin
                    if (s.cnt < 16'(KW_CHARS)) begin
                        s.wch[{3'd7 - s.cnt[2:0], 3'b000} +: 8] = c;
                    end
                    s = bump(s);
                end else begin
                    recs[k] = flush_word(s);
                    k = k + 2'd1;
                    s = start_token(s, c, r, e);
                    if (e) begin
                        recs[k] = r;
                        k = k + 2'd1;
                    end
                end
            end
            M_CONST: begin
                if (is_digit(c) || c == "." || (is_alpha(c) && c != "_")) begin
                    s = bump(s);
                end else begin
                    recs[k] = '{cls: CLS_CONST, idx: 6'd0, len: s.cnt, last: 1'b0};
                    k = k + 2'd1;
                    s = start_token(s, c, r, e);
                    if (e) begin
                        recs[k] = r;
                        k = k + 2'd1;
                    end
                end
            end
            M_LIT: begin
                s = bump(s);
                if (s.esc) begin
                    s.esc = 1'b0;
                end else if (c == 8'h5C) begin
                    s.esc = 1'b1;
                end else if (c == s.quote) begin
                    recs[k] = '{cls: CLS_LIT, idx: 6'd0, len: s.cnt, last: 1'b0};
                    k = k + 2'd1;
                    s = to_idle(s);
                end
            end
            M_LINE: begin
                if (c == 8'h0A) begin
                    recs[k] = '{cls: CLS_LINE, idx: 6'd0, len: s.cnt, last: 1'b0};
                    k = k + 2'd1;
                    s = to_idle(s);
                end else begin
                    s = bump(s);
                end
            end
            M_BLOCK: begin
                s = bump(s);
                if (s.star && c == "/") begin
                    recs[k] = '{cls: CLS_BLOCK, idx: 6'd0, len: s.cnt, last: 1'b0};
                    k = k + 2'd1;
                    s = to_idle(s);
                end else begin
                    s.star = (c == "*");
                end
            end
            M_OPER: begin
                if (n == 2'd0) begin
                    s = start_token(s, c, r, e);
                    if (e) begin
                        recs[k] = r;
                        k = k + 2'd1;
                    end
                end else if (n == 2'd1 && s0 == "/" && (c == "/" || c == "*")) begin
                    s = to_idle(s);
                    s.mode = (c == "/") ? M_LINE : M_BLOCK;
                    s.cnt  = 16'd2;
                end else if (n == 2'd1 && op_prefix({s0, c, 8'h0}, 2'd2)) begin
                    s.pend = {c, s0};
                    s.pcnt = 2'd2;
                end else if (n == 2'd2 && op_prefix({s0, s1, c}, 2'd3)) begin
                    recs[k] = op_record({s0, s1, c}, 2'd3);
                    k = k + 2'd1;
                    s = to_idle(s);
                end else begin
                    recs[k] = op_record({s0, s1, 8'h0}, n);
                    k = k + 2'd1;
                    s = start_token(s, c, r, e);
                    if (e) begin
                        recs[k] = r;
                        k = k + 2'd1;
                    end
                end
            end
            default: begin
                s = start_token(s, c, r, e);
                if (e) begin
                    recs[k] = r;
                    k = k + 2'd1;
                end
            end
        endcase

        if (eot) begin
            n = (s.pcnt == 2'd3) ? 2'd2 : s.pcnt;
            case (s.mode)
                M_WORD: begin
                    recs[k] = flush_word(s);
                    k = k + 2'd1;
                end
                M_CONST: begin
                    recs[k] = '{cls: CLS_CONST, idx: 6'd0, len: s.cnt, last: 1'b0};
                    k = k + 2'd1;
                end
                M_LIT, M_BLOCK: begin
                    recs[k] = '{cls: CLS_UNTERM, idx: 6'd0, len: s.cnt, last: 1'b0};
                    k = k + 2'd1;
                end
                M_LINE: begin
                    recs[k] = '{cls: CLS_LINE, idx: 6'd0, len: s.cnt, last: 1'b0};
                    k = k + 2'd1;
                end
                M_OPER: begin
                    if (n != 2'd0) begin
                        recs[k] = op_record({s.pend[7:0], s.pend[15:8], 8'h0}, n);
                        k = k + 2'd1;
                    end
                end
                default: begin
                    k = k;
                end
            endcase
            s = to_idle(s);
        end

        if (k != 2'd0) begin
            recs[k - 2'd1].last = 1'b1;
        end

        st_next  = s;
        push.rec = recs;
        push.cnt = fire ? k : 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '{mode: M_IDLE, default: '0};
        end else if (fire) begin
            st_reg <= st_next;
        end
    end

endmodule

[design/ctk_queue.sv]
// Result queue: takes up to three records per cycle, hands out one per cycle while out_ready is high.
module ctk_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  ctk_pkg::push_t push,
    output logic           room,
    output logic           out_valid,
    input  logic           out_ready,
    output ctk_pkg::rec_t  out_rec
);
    import ctk_pkg::*;

    rec_t q_reg [QUEUE_DEPTH];
    logic [1:0] head_reg, tail_reg;
    logic [2:0] count_reg, count_next;
    logic [2:0] after_pop;
    logic pop;

    assign out_valid  = aresetn && (count_reg != 3'd0);
    assign pop        = out_valid && out_ready;
    assign after_pop  = count_reg - {2'd0, pop};
    assign room       = aresetn && (after_pop <= 3'd1);
    assign count_next = after_pop + {1'b0, push.cnt};
    assign out_rec    = q_reg[head_reg];

    always_ff @(posedge aclk) begin
        for (int j = 0; j < 3; j++) begin
            if (2'(j) < push.cnt) begin
                q_reg[tail_reg + 2'(j)] <= push.rec[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_reg + {1'b0, pop};
            tail_reg  <= tail_reg + push.cnt;
            count_reg <= count_next;
        end
    end

endmodule

[design/c_source_tokenizer.sv]
// Top level of the C source tokenizer.
// Takes one source byte per cycle while s_ready is high and emits token records
// (class, table index, length, last-of-run) when tokens end. Each byte is scanned
// in the cycle it is accepted and its up to two records enter a four-entry result
// queue; a byte is accepted whenever at most one record is left in the queue after
// this cycle's read, so with a ready consumer and one record or less per byte the
// block takes a byte every cycle, and a byte yielding more records holds off input
// until the queue has drained back to at most one record after the read.
module c_source_tokenizer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_source_byte,
    input  logic        s_end_of_text,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_token_class,
    output logic [5:0]  m_table_index,
    output logic [15:0] m_token_length,
    output logic        m_last_of_run
);
    import ctk_pkg::*;

    push_t push;
    rec_t  head;
    logic  fire;

    assign fire = s_valid && s_ready;

    ctk_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .char_in (s_source_byte),
        .eot     (s_end_of_text),
        .push    (push)
    );

    ctk_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_rec   (head)
    );

    assign m_token_class  = head.cls;
    assign m_table_index  = head.idx;
    assign m_token_length = head.len;
    assign m_last_of_run  = head.last;

endmodule
